@@ rtl/core/occupancy_light_mode_controller_top_assert.svh @@
// Assertion macros shared by the lamp controller RTL.
`ifndef OCCUPANCY_LIGHT_MODE_CONTROLLER_TOP_ASSERT_SVH
`define OCCUPANCY_LIGHT_MODE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OLMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/olmc_pkg.sv @@
// Types, codes and constants shared by the lamp controller RTL.
package olmc_pkg;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_ON     = 2'd1,
    KIND_OFF    = 2'd2,
    KIND_MANUAL = 2'd3
  } olmc_kind_t;

  localparam logic [2:0] CFG_OFF_DELAY      = 3'd0;
  localparam logic [2:0] CFG_SENSOR_PERIOD  = 3'd1;
  localparam logic [2:0] CFG_RANGE_PERIOD   = 3'd2;
  localparam logic [2:0] CFG_REPORT_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_NEAR_LOW       = 3'd4;
  localparam logic [2:0] CFG_NEAR_HIGH      = 3'd5;

  localparam int unsigned AMBIENT_FULL_SCALE_DEF = 4095;
  localparam int unsigned FULL_SCALE_W = 16;

  localparam int unsigned DUTY_FULL = 100;
  localparam int unsigned DUTY_W    = 7;

  localparam logic [31:0] OFF_DELAY_RST     = 32'd20000;
  localparam logic [15:0] SENSOR_PERIOD_RST = 16'd200;
  localparam logic [15:0] RANGE_PERIOD_RST  = 16'd300;
  localparam logic [15:0] REPORT_PERIOD_RST = 16'd1000;
  localparam logic [15:0] NEAR_LOW_RST      = 16'd20;
  localparam logic [15:0] NEAR_HIGH_RST     = 16'd1200;
  localparam logic [7:0]  MANUAL_LEVEL_RST  = 8'd80;

  // Tenths of a cm to rounded cm: (r + 5) / 10 as an exact reciprocal multiply.
  localparam int unsigned RANGE_SUM_W   = 17;
  localparam logic [16:0] RANGE_ROUND   = 17'd5;
  localparam int unsigned RANGE_SHIFT   = 20;
  localparam logic [16:0] RANGE_RECIP   = 17'd104858;
  localparam int unsigned RANGE_PROD_W  = 34;
  localparam int unsigned CM_W          = 13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  level;
    logic [31:0] now_ms;
    logic [11:0] ambient_reading;
    logic        motion_seen;
    logic [15:0] range_tenths;
    logic        range_ok;
  } olmc_in_t;

  typedef struct packed {
    logic        light_on;
    logic [7:0]  brightness;
    logic        report_valid;
    logic [12:0] report_distance_cm;
    logic [11:0] report_ambient;
  } olmc_out_t;

  // Item leaving the scaling pipeline, with its derived values.
  typedef struct packed {
    logic                valid;
    olmc_in_t            item;
    logic [DUTY_W-1:0]   duty;
    logic [CM_W-1:0]     cm;
  } olmc_prep_t;

endpackage

@@ rtl/core/olmc_prep.sv @@
// Two-stage pipeline that derives the auto duty and the rounded distance of an item.
module olmc_prep #(
  parameter int unsigned AMBIENT_FULL_SCALE = olmc_pkg::AMBIENT_FULL_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               item_valid,
  input  olmc_pkg::olmc_in_t item,
  output olmc_pkg::olmc_prep_t prep
);
  import olmc_pkg::*;

  localparam int unsigned XMax = DUTY_FULL * AMBIENT_FULL_SCALE;
  localparam int unsigned XW = $clog2(XMax + 1);
  localparam longint unsigned ExactBound =
    longint'(XMax) * longint'(AMBIENT_FULL_SCALE) + 1;
  localparam int unsigned Shift = $clog2(ExactBound);
  localparam longint unsigned RecipM =
    ((longint'(1) << Shift) + AMBIENT_FULL_SCALE - 1) / AMBIENT_FULL_SCALE;
  localparam int unsigned MW = $clog2(RecipM + 1);
  localparam int unsigned ProdW = XW + MW;
  localparam logic [FULL_SCALE_W-1:0] FullScale = FULL_SCALE_W'(AMBIENT_FULL_SCALE);

  logic                   v1;
  olmc_in_t               item1;
  logic [XW-1:0]          scaled;
  logic [RANGE_SUM_W-1:0] range_sum;

  logic [FULL_SCALE_W-1:0] headroom;
  logic [ProdW-1:0]        duty_prod;
  logic [RANGE_PROD_W-1:0] cm_prod;

  // Ambient above full scale gives no auto light.
  assign headroom = ({4'd0, item.ambient_reading} > FullScale) ? '0
                  : FullScale - {4'd0, item.ambient_reading};

  assign duty_prod = ProdW'(scaled) * ProdW'(RecipM);
  assign cm_prod   = RANGE_PROD_W'(range_sum) * RANGE_PROD_W'(RANGE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      prep.valid <= 1'b0;
    end else if (en) begin
      v1         <= item_valid;
      prep.valid <= v1;
    end
    if (en) begin
      item1     <= item;
      scaled    <= XW'(headroom * DUTY_FULL);
      range_sum <= {1'b0, item.range_tenths} + RANGE_ROUND;
      prep.item <= item1;
      prep.duty <= duty_prod[Shift +: DUTY_W];
      prep.cm   <= cm_prod[RANGE_SHIFT +: CM_W];
    end
  end

endmodule

@@ rtl/core/occupancy_light_mode_controller_top.sv @@
// Top level of the occupancy lamp mode controller.
//
//   channel | direction | handshake                  | beat
//   --------+-----------+----------------------------+---------------------------------
//   item    | in        | item_valid / item_stall    | command or sensor update
//   result  | out       | result_valid / result_stall| lamp state and optional report
//   cfg     | in        | cfg_valid / cfg_ready      | register index and write data
//
// One item beat can be taken every cycle while item_stall is low. An update beat
// passes through the first scaling stage, then the second, and then the state stage
// loads the result register, from which the beat is offered on the result channel.
// Command beats give no result.
// The whole pipeline holds while a result waits under result_stall, so item_stall
// follows result_stall in the same cycle.
// rst is synchronous and clears the pipeline valids, the mode and the timers;
// the configuration port is always ready.
module occupancy_light_mode_controller_top #(
  parameter int unsigned AMBIENT_FULL_SCALE = olmc_pkg::AMBIENT_FULL_SCALE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  olmc_pkg::olmc_in_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output olmc_pkg::olmc_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import olmc_pkg::*;

  // Configuration registers.
  logic [31:0] off_delay_ms;
  logic [15:0] sensor_period_ms;
  logic [15:0] distance_period_ms;
  logic [15:0] report_period_ms;
  logic [15:0] near_low_tenths;
  logic [15:0] near_high_tenths;

  // Controller state. The duty and the rounded distance are kept next to the
  // readings they were derived from.
  olmc_kind_t        mode;
  logic [7:0]        manual_level;
  logic [31:0]       last_presence_ms;
  logic [31:0]       last_sensor_ms;
  logic [31:0]       last_range_ms;
  logic [31:0]       last_report_ms;
  logic [11:0]       ambient_latched;
  logic [DUTY_W-1:0] duty_latched;
  logic              motion_latched;
  logic [15:0]       range_latched;
  logic [CM_W-1:0]   cm_latched;
  logic              range_valid_latched;

  olmc_prep_t prep;
  logic       en;
  logic       is_update;
  logic       is_command;

  // The pipeline moves whenever the result register is free or being emptied.
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  olmc_prep #(
    .AMBIENT_FULL_SCALE(AMBIENT_FULL_SCALE)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_valid(item_valid),
    .item      (item),
    .prep      (prep)
  );

  assign is_update  = prep.valid && (prep.item.kind == KIND_UPDATE);
  assign is_command = prep.valid && (prep.item.kind != KIND_UPDATE);

  // Next state for an update beat.
  logic [31:0]       sensor_age;
  logic [31:0]       range_age;
  logic [31:0]       report_age;
  logic [31:0]       presence_age;
  logic              sensor_due;
  logic              range_due;
  logic              report_due;
  logic [11:0]       ambient_next;
  logic [DUTY_W-1:0] duty_next;
  logic              motion_next;
  logic [15:0]       range_next;
  logic [CM_W-1:0]   cm_next;
  logic              range_valid_next;
  logic              near;
  logic [31:0]       last_presence_next;
  olmc_out_t         result_next;

  always_comb begin
    sensor_age = prep.item.now_ms - last_sensor_ms;
    range_age  = prep.item.now_ms - last_range_ms;
    report_age = prep.item.now_ms - last_report_ms;
    sensor_due = sensor_age >= {16'd0, sensor_period_ms};
    range_due  = range_age >= {16'd0, distance_period_ms};
    report_due = report_age >= {16'd0, report_period_ms};

    ambient_next     = sensor_due ? prep.item.ambient_reading : ambient_latched;
    duty_next        = sensor_due ? prep.duty : duty_latched;
    motion_next      = sensor_due ? prep.item.motion_seen : motion_latched;
    range_next       = range_due ? prep.item.range_tenths : range_latched;
    cm_next          = range_due ? prep.cm : cm_latched;
    range_valid_next = range_due ? prep.item.range_ok : range_valid_latched;

    // A valid distance strictly inside the near window counts as presence.
    near = range_valid_next && (range_next > near_low_tenths)
        && (range_next < near_high_tenths);
    last_presence_next = (motion_next || near) ? prep.item.now_ms : last_presence_ms;
    presence_age       = prep.item.now_ms - last_presence_next;

    result_next = '0;
    unique case (mode)
      KIND_ON: begin
        result_next.light_on   = 1'b1;
        result_next.brightness = 8'(DUTY_FULL);
      end
      KIND_OFF: begin
        result_next.light_on   = 1'b0;
        result_next.brightness = '0;
      end
      KIND_MANUAL: begin
        result_next.light_on   = 1'b1;
        result_next.brightness = manual_level;
      end
      KIND_UPDATE: begin
        result_next.light_on   = presence_age <= off_delay_ms;
        result_next.brightness = result_next.light_on ? {1'b0, duty_next} : '0;
      end
      default: begin
        result_next.light_on   = 1'b0;
        result_next.brightness = '0;
      end
    endcase

    if (report_due) begin
      result_next.report_valid       = 1'b1;
      result_next.report_distance_cm =
        (range_valid_next && (range_next != 16'd0)) ? cm_next : '0;
      result_next.report_ambient     = ambient_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_delay_ms        <= OFF_DELAY_RST;
      sensor_period_ms    <= SENSOR_PERIOD_RST;
      distance_period_ms  <= RANGE_PERIOD_RST;
      report_period_ms    <= REPORT_PERIOD_RST;
      near_low_tenths     <= NEAR_LOW_RST;
      near_high_tenths    <= NEAR_HIGH_RST;
      mode                <= KIND_UPDATE;
      manual_level        <= MANUAL_LEVEL_RST;
      last_presence_ms    <= '0;
      last_sensor_ms      <= '0;
      last_range_ms       <= '0;
      last_report_ms      <= '0;
      ambient_latched     <= '0;
      // A dark room (ambient zero) gives the full auto duty.
      duty_latched        <= DUTY_W'(DUTY_FULL);
      motion_latched      <= 1'b0;
      range_latched       <= '0;
      cm_latched          <= '0;
      range_valid_latched <= 1'b0;
      result_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_OFF_DELAY:     off_delay_ms       <= cfg_data;
          CFG_SENSOR_PERIOD: sensor_period_ms   <= cfg_data[15:0];
          CFG_RANGE_PERIOD:  distance_period_ms <= cfg_data[15:0];
          CFG_REPORT_PERIOD: report_period_ms   <= cfg_data[15:0];
          CFG_NEAR_LOW:      near_low_tenths    <= cfg_data[15:0];
          CFG_NEAR_HIGH:     near_high_tenths   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (en) begin
        result_valid <= is_update;
        if (is_command) begin
          mode <= olmc_kind_t'(prep.item.kind);
          if (prep.item.kind == KIND_MANUAL) begin
            manual_level <= prep.item.level;
          end
        end
        if (is_update) begin
          if (sensor_due) begin
            last_sensor_ms <= prep.item.now_ms;
          end
          if (range_due) begin
            last_range_ms <= prep.item.now_ms;
          end
          if (report_due) begin
            last_report_ms <= prep.item.now_ms;
          end
          ambient_latched     <= ambient_next;
          duty_latched        <= duty_next;
          motion_latched      <= motion_next;
          range_latched       <= range_next;
          cm_latched          <= cm_next;
          range_valid_latched <= range_valid_next;
          last_presence_ms    <= last_presence_next;
        end
      end
    end
  end

  // The result register itself needs no reset.
  always_ff @(posedge clk) begin
    if (en && is_update) begin
      result <= result_next;
    end
  end

  `include "occupancy_light_mode_controller_top_assert.svh"

  // A command beat leaving the pipeline never produces a result beat.
  `OLMC_ASSERT_NEXT(a_cmd_silent, en && is_command, !result_valid, "command produced a result")
  // A dark lamp never reports a brightness.
  `OLMC_ASSERT_NOW(a_dark_zero, result_valid && !result.light_on, result.brightness == 8'd0, "brightness while off")
  // Report fields are zero unless a report is flagged.
  `OLMC_ASSERT_NOW(a_report_zero, result_valid && !result.report_valid, (result.report_distance_cm == '0) && (result.report_ambient == '0), "stale report fields")
  // Forced-on mode always gives full brightness.
  `OLMC_ASSERT_NEXT(a_force_on, en && is_update && (mode == KIND_ON), result.light_on && (result.brightness == 8'(DUTY_FULL)), "forced-on result wrong")

endmodule
